[design/mmh_pkg.sv]
// Shared constants and types of the MurmurHash3 engine.
`default_nettype none
package mmh_pkg;

  localparam logic [31:0] C1 = 32'hcc9e2d51;
  localparam logic [31:0] C2 = 32'h1b873593;
  localparam logic [31:0] MixAdd = 32'he6546b64;
  localparam logic [31:0] F1 = 32'h85ebca6b;
  localparam logic [31:0] F2 = 32'hc2b2ae35;

  localparam logic [2:0] FullBytes = 3'd4;

  // What the back end does with one queued word.
  typedef enum logic [1:0] {
    KIND_BLOCK     = 2'd0,
    KIND_LAST_FULL = 2'd1,
    KIND_LAST_TAIL = 2'd2
  } word_kind_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  len_inc;
    word_kind_t  kind;
  } q_entry_t;

endpackage
`default_nettype wire

[design/murmur3_hash_engine_core.sv]
// Top level of the streaming MurmurHash3 (x86, 32-bit) engine.
// Streams a message as little-endian 32-bit words (first byte in bits 7:0) and returns
// one 32-bit MurmurHash3 per message, on the word marked last. The hash of every message
// starts from the seed register, sampled when the first word of the message reaches the
// back end; a seed written mid-message applies from the next message. A non-last word
// counts four bytes; the last word carries 0 to 4 bytes (larger counts act as 4). Words
// pass through a two-entry queue into the back-end sequencer, which takes one word at a
// time and has one 32-bit multiplier stage per cycle: a non-last word goes through the
// scramble multiply, rotate-multiply and mix, a last word through these plus two finalizer
// multiplies and the output load, which waits while the previous hash is still untaken.
// The input accepts words while the queue has room; a stalled output can fill the queue.
`default_nettype none
module murmur3_hash_engine_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_data_word,
  input  wire logic [2:0]  in_byte_count,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_hash_value
);

  logic [31:0]       seed_r;
  logic              q_valid;
  logic              q_pop;
  mmh_pkg::q_entry_t q_entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= 32'd0;
    end else if (cfg_wr_en) begin
      seed_r <= cfg_wr_data;
    end
  end

  mmh_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_word  (in_data_word),
    .in_byte_count (in_byte_count),
    .in_last       (in_last),
    .q_valid       (q_valid),
    .q_entry       (q_entry),
    .q_pop         (q_pop)
  );

  mmh_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .seed           (seed_r),
    .q_valid        (q_valid),
    .q_entry        (q_entry),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hash_value (out_hash_value)
  );

endmodule
`default_nettype wire

[design/mmh_front.sv]
// Front end: classifies input words, masks tails and queues them for the back end.
`default_nettype none
module mmh_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [31:0]     in_data_word,
  input  wire logic [2:0]      in_byte_count,
  input  wire logic            in_last,
  output logic                 q_valid,
  output mmh_pkg::q_entry_t    q_entry,
  input  wire logic            q_pop
);

  mmh_pkg::q_entry_t slot_r [2];
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic [1:0]        count_r, count_nxt;
  mmh_pkg::q_entry_t entry_in;
  logic [2:0]        cnt_sat;
  logic [31:0]       mask;
  logic              push;

  // Saturate the byte count and pick the tail mask.
  always_comb begin
    cnt_sat = (in_byte_count > mmh_pkg::FullBytes) ? mmh_pkg::FullBytes : in_byte_count;
    case (cnt_sat)
      3'd0:    mask = 32'h0000_0000;
      3'd1:    mask = 32'h0000_00ff;
      3'd2:    mask = 32'h0000_ffff;
      3'd3:    mask = 32'h00ff_ffff;
      default: mask = 32'hffff_ffff;
    endcase
    if (!in_last) begin
      entry_in.word    = in_data_word;
      entry_in.len_inc = mmh_pkg::FullBytes;
      entry_in.kind    = mmh_pkg::KIND_BLOCK;
    end else if (cnt_sat == mmh_pkg::FullBytes) begin
      entry_in.word    = in_data_word;
      entry_in.len_inc = cnt_sat;
      entry_in.kind    = mmh_pkg::KIND_LAST_FULL;
    end else begin
      entry_in.word    = in_data_word & mask;
      entry_in.len_inc = cnt_sat;
      entry_in.kind    = mmh_pkg::KIND_LAST_TAIL;
    end
  end

  assign in_ready = (count_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != 2'd0);
  assign q_entry  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= entry_in;
    end
  end

endmodule
`default_nettype wire

[design/mmh_back.sv]
// Back end: scrambles queued words, folds them into the hash and runs the finalizer.
`default_nettype none
module mmh_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [31:0]       seed,
  input  wire logic              q_valid,
  input  wire mmh_pkg::q_entry_t q_entry,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [31:0]            out_hash_value
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_K2   = 6'b000010,
    S_MIX  = 6'b000100,
    S_F0   = 6'b001000,
    S_F1   = 6'b010000,
    S_F2   = 6'b100000
  } state_t;

  state_t               state_r, state_nxt;
  logic                 in_msg_r, in_msg_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [31:0]          out_hash_r, out_hash_nxt;
  logic [31:0]          k_r, k_nxt;
  logic [31:0]          h_r, h_nxt;
  logic [31:0]          len_r, len_nxt;
  mmh_pkg::word_kind_t  kind_r, kind_nxt;
  logic [31:0]          h_x, h_rot, h_mix, t_f;
  logic                 out_free;

  assign out_free = !out_valid_r || out_ready;
  assign q_pop    = (state_r == S_IDLE) && q_valid;

  always_comb begin
    h_x   = h_r ^ k_r;
    h_rot = {h_x[18:0], h_x[31:19]};
    h_mix = (kind_r == mmh_pkg::KIND_LAST_TAIL) ? h_x
          : ({h_rot[29:0], 2'b00} + h_rot + mmh_pkg::MixAdd);
    t_f   = 32'd0;

    state_nxt     = state_r;
    in_msg_nxt    = in_msg_r;
    out_valid_nxt = (out_valid_r && out_ready) ? 1'b0 : out_valid_r;
    out_hash_nxt  = out_hash_r;
    k_nxt         = k_r;
    h_nxt         = h_r;
    len_nxt       = len_r;
    kind_nxt      = kind_r;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          k_nxt      = q_entry.word * mmh_pkg::C1;
          kind_nxt   = q_entry.kind;
          in_msg_nxt = 1'b1;
          // Load the seed on the first word of a message.
          if (!in_msg_r) begin
            h_nxt   = seed;
            len_nxt = {29'd0, q_entry.len_inc};
          end else begin
            len_nxt = len_r + {29'd0, q_entry.len_inc};
          end
          state_nxt = S_K2;
        end
      end
      S_K2: begin
        k_nxt     = {k_r[16:0], k_r[31:17]} * mmh_pkg::C2;
        state_nxt = S_MIX;
      end
      S_MIX: begin
        if (kind_r == mmh_pkg::KIND_BLOCK) begin
          h_nxt     = h_mix;
          state_nxt = S_IDLE;
        end else begin
          h_nxt     = h_mix ^ len_r;
          state_nxt = S_F0;
        end
      end
      S_F0: begin
        t_f       = h_r ^ {16'd0, h_r[31:16]};
        h_nxt     = t_f * mmh_pkg::F1;
        state_nxt = S_F1;
      end
      S_F1: begin
        t_f       = h_r ^ {13'd0, h_r[31:13]};
        h_nxt     = t_f * mmh_pkg::F2;
        state_nxt = S_F2;
      end
      S_F2: begin
        // Hold until the output register is free.
        if (out_free) begin
          out_hash_nxt  = h_r ^ {16'd0, h_r[31:16]};
          out_valid_nxt = 1'b1;
          in_msg_nxt    = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_msg_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_msg_r    <= in_msg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_hash_r <= out_hash_nxt;
    k_r        <= k_nxt;
    h_r        <= h_nxt;
    len_r      <= len_nxt;
    kind_r     <= kind_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;

endmodule
`default_nettype wire

[design/mmh_checker.sv]
// Port-level checks of the MurmurHash3 engine, bound to the top level.
`default_nettype none
module mmh_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_hash_value
);

  // Reset empties the queue and drops any pending hash.
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("hash valid right after reset");

  a_reset_ready: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready right after reset");

  // Hold a stalled hash until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hash_value))
    else $error("stalled hash changed or dropped");

endmodule

bind murmur3_hash_engine_core mmh_checker u_mmh_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_hash_value (out_hash_value)
);
`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the streaming MurmurHash3 engine.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned SettleCycles = 20;
  localparam int unsigned NumDirected = 21;
  localparam int unsigned NumRandom = 700;
  localparam int unsigned QuietTail = 120;

  // One row of the directed stimulus table.
  typedef struct packed {
    logic        load_seed;
    logic [31:0] seed_value;
    logic [31:0] word;
    logic [2:0]  count;
    logic        last;
    logic        has_known;
    logic [31:0] known_hash;
  } word_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_data_word;
  logic [2:0]  in_byte_count;
  logic        in_last;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_hash_value;

  // Shadow of the hash state.
  logic [31:0] hash_seed;
  logic [31:0] run_hash;
  logic [31:0] msg_len;
  logic        msg_open;

  logic [31:0] owed_hashes[$];
  logic [31:0] owed_head;
  word_row_t   directed_rows[NumDirected];

  int unsigned err_count;
  int unsigned cycle_count;
  int unsigned hashes_seen;
  int unsigned words_sent;
  int unsigned seeds_used;
  int unsigned ready_hold;
  bit          idle_on;

  murmur3_hash_engine_core uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_word  (in_data_word),
    .in_byte_count (in_byte_count),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_hash_value(out_hash_value)
  );

  always #4 clk = ~clk;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
    return (x << r) | (x >> (32 - r));
  endfunction

  function automatic logic [31:0] scramble_word(input logic [31:0] k);
    logic [31:0] t;
    t = k * 32'hcc9e2d51;
    t = rotl(t, 15);
    return t * 32'h1b873593;
  endfunction

  function automatic logic [31:0] mix_word(input logic [31:0] h, input logic [31:0] k);
    logic [31:0] t;
    t = rotl(h ^ scramble_word(k), 13);
    return t * 32'd5 + 32'he6546b64;
  endfunction

  function automatic logic [31:0] final_mix(input logic [31:0] h, input logic [31:0] len);
    logic [31:0] t;
    t = h ^ len;
    t = t ^ (t >> 16);
    t = t * 32'h85ebca6b;
    t = t ^ (t >> 13);
    t = t * 32'hc2b2ae35;
    return t ^ (t >> 16);
  endfunction

  // Fold one word into the shadow state; report a hash when the message closes.
  function automatic void hash_word(input logic [31:0] w, input logic [2:0] c, input logic l,
                                    output logic done, output logic [31:0] hv);
    logic [31:0] h;
    logic [2:0]  n;
    logic [31:0] mask;
    if (!msg_open) begin
      run_hash = hash_seed;
      msg_len = '0;
      msg_open = 1'b1;
    end
    h = run_hash;
    done = 1'b0;
    hv = '0;
    if (!l) begin
      run_hash = mix_word(h, w);
      msg_len = msg_len + 32'd4;
    end else begin
      n = (c > 3'd4) ? 3'd4 : c;
      if (n == 3'd4) begin
        h = mix_word(h, w);
      end else begin
        mask = (32'd1 << (8 * int'(n))) - 32'd1;
        h = h ^ scramble_word(w & mask);
      end
      msg_len = msg_len + 32'(n);
      hv = final_mix(h, msg_len);
      done = 1'b1;
      run_hash = hash_seed;
      msg_open = 1'b0;
    end
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_word(input logic [31:0] w, input logic [2:0] c, input logic l,
                           input logic has_known, input logic [31:0] known);
    int unsigned gap;
    logic        done;
    logic [31:0] hv;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data_word <= w;
    in_byte_count <= c;
    in_last <= l;
    do @(posedge clk); while (!in_ready);
    hash_word(w, c, l, done, hv);
    if (done) owed_hashes.push_back(has_known ? known : hv);
    words_sent++;
    @(negedge clk);
  endtask

  // Drain, let the back end settle, then load a new seed.
  task automatic load_seed(input logic [31:0] value);
    in_valid <= 1'b0;
    while (owed_hashes.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    hash_seed = value;
    seeds_used++;
  endtask

  task automatic send_random_message(input int unsigned budget, output int unsigned used);
    int unsigned nwords;
    int unsigned i;
    logic [2:0]  c;
    nwords = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 24) : $urandom_range(0, 4);
    if (nwords + 1 > budget) nwords = (budget > 0) ? budget - 1 : 0;
    for (i = 0; i < nwords; i++) begin
      c = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
      send_word($urandom, c, 1'b0, 1'b0, '0);
    end
    send_word($urandom, 3'($urandom_range(0, 7)), 1'b1, 1'b0, '0);
    used = nwords + 1;
  endtask

  // Output back-pressure in short bursts.
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      ready_hold <= $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      hashes_seen++;
      if (owed_hashes.size() == 0) begin
        $error("out_hash_value: no hash expected, got %08h", out_hash_value);
        err_count++;
      end else begin
        owed_head = owed_hashes.pop_front();
        if (out_hash_value !== owed_head) begin
          $error("out_hash_value: expected %08h, got %08h", owed_head, out_hash_value);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("murmur3_hash_engine_core test failed");
      $finish;
    end
  end

  initial begin
    int unsigned r;
    int unsigned sent;
    int unsigned used;
    int unsigned phase_end;
    int unsigned ph;
    logic [31:0] phase_seeds[5];

    clk = 1'b0;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_data_word = '0;
    in_byte_count = '0;
    in_last = 1'b0;
    out_ready = 1'b1;
    ready_hold = 0;
    idle_on = 1'b0;
    err_count = 0;
    cycle_count = 0;
    hashes_seen = 0;
    words_sent = 0;
    seeds_used = 1;
    hash_seed = '0;
    run_hash = '0;
    msg_len = '0;
    msg_open = 1'b0;

    // seed, word, count, last, known hash where it is a published value
    directed_rows = '{
      '{1'b0, 32'h0,        32'hffffffff, 3'd0, 1'b1, 1'b1, 32'h00000000},
      '{1'b1, 32'h1,        32'h00000000, 3'd0, 1'b1, 1'b1, 32'h514e28b7},
      '{1'b1, 32'hffffffff, 32'h12345678, 3'd0, 1'b1, 1'b1, 32'h81f16f39},
      '{1'b1, 32'h0,        32'h00000000, 3'd4, 1'b1, 1'b1, 32'h2362f9de},
      '{1'b0, 32'h0,        32'hffffffff, 3'd4, 1'b1, 1'b0, 32'h0},
      '{1'b0, 32'h0,        32'hffffffff, 3'd1, 1'b1, 1'b0, 32'h0},
      '{1'b0, 32'h0,        32'hffffffff, 3'd2, 1'b1, 1'b0, 32'h0},
      '{1'b0, 32'h0,        32'hffffffff, 3'd3, 1'b1, 1'b0, 32'h0},
      '{1'b0, 32'h0,        32'ha5a5a5a5, 3'd5, 1'b1, 1'b0, 32'h0},
      '{1'b0, 32'h0,        32'h5a5a5a5a, 3'd6, 1'b1, 1'b0, 32'h0},
      '{1'b0, 32'h0,        32'hffffffff, 3'd7, 1'b1, 1'b0, 32'h0},
      '{1'b0, 32'h0,        32'h00000000, 3'd0, 1'b0, 1'b0, 32'h0},
      '{1'b0, 32'h0,        32'hffffffff, 3'd7, 1'b0, 1'b0, 32'h0},
      '{1'b0, 32'h0,        32'h80000001, 3'd3, 1'b1, 1'b0, 32'h0},
      '{1'b1, 32'h9747b28c, 32'h6c6c6548, 3'd4, 1'b0, 1'b0, 32'h0},
      '{1'b0, 32'h0,        32'h77202c6f, 3'd4, 1'b0, 1'b0, 32'h0},
      '{1'b0, 32'h0,        32'h646c726f, 3'd4, 1'b0, 1'b0, 32'h0},
      '{1'b0, 32'h0,        32'h00000021, 3'd1, 1'b1, 1'b0, 32'h0},
      '{1'b1, 32'h0,        32'hffffffff, 3'd4, 1'b0, 1'b0, 32'h0},
      '{1'b0, 32'h0,        32'hffffffff, 3'd4, 1'b0, 1'b0, 32'h0},
      '{1'b0, 32'h0,        32'hffffffff, 3'd0, 1'b1, 1'b0, 32'h0}
    };

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (r = 0; r < NumDirected; r++) begin
      if (directed_rows[r].load_seed) load_seed(directed_rows[r].seed_value);
      send_word(directed_rows[r].word, directed_rows[r].count, directed_rows[r].last,
                directed_rows[r].has_known, directed_rows[r].known_hash);
    end

    // Random messages under a spread of seeds, including both extremes.
    phase_seeds = '{$urandom, 32'hffffffff, 32'h0, $urandom, $urandom};
    sent = 0;
    for (ph = 0; ph < 5; ph++) begin
      load_seed(phase_seeds[ph]);
      phase_end = (ph == 4) ? NumRandom : (ph + 1) * (NumRandom - QuietTail) / 4;
      while (sent < phase_end) begin
        // Quiet final phase; elsewhere idling comes and goes per message.
        idle_on = (ph != 4) && ($urandom_range(0, 3) != 0);
        send_random_message(phase_end - sent, used);
        sent += used;
      end
    end
    idle_on = 1'b0;
    in_valid <= 1'b0;

    while (owed_hashes.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);

    $display("Sent %0d words (%0d from the table), checked %0d hashes under %0d seeds.",
             words_sent, NumDirected, hashes_seen, seeds_used);
    $display("Tails of 0..7 bytes, empty messages, long messages and both seed extremes seen.");
    if (err_count == 0) begin
      $display("murmur3_hash_engine_core test passed");
    end else begin
      $display("murmur3_hash_engine_core test failed");
    end
    $finish;
  end

endmodule

[filelist.f]
design/mmh_pkg.sv
design/mmh_front.sv
design/mmh_back.sv
design/murmur3_hash_engine_core.sv
design/mmh_checker.sv
tb/tb.sv
